[rtl/mfs_pkg.sv]
// Shared types, constants and the control program of the muscle force step.
// Used by mfs_useq, mfs_datapath and muscle_force_step; depends on nothing.
package mfs_pkg;

    // Field widths
    localparam int LEN_W    = 16;
    localparam int PERIOD_W = 11;
    localparam int DATA_W   = 32;
    localparam int PC_W     = 4;

    // Reset value of the spike period register
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd102;

    // Filter feedback coefficients, Q2.30
    localparam logic signed [31:0] COEF_A1 = 32'sd2085206622;
    localparam logic signed [31:0] COEF_A2 = 32'sd1012538540;
    // Spike terms 2299 and 2289, Q16.16
    localparam logic signed [31:0] COEF_B0_Q16 = 32'sd150667264;
    localparam logic signed [31:0] COEF_B1_Q16 = 32'sd150011904;
    // Force update: T' = T + (136*A - 211*T) / 51200
    localparam logic signed [31:0] KSE_NUM  = 32'sd136;
    localparam logic signed [31:0] DAMP_NUM = 32'sd211;
    localparam logic [39:0]        STEP_HALF = 40'd25600;
    // ceil(2^34 / 25): exact quotient by 25 for dividends below 2^29
    localparam logic signed [31:0] RECIP_25 = 32'sd687194768;

    // Length breakpoints, Q2.14
    localparam logic [16:0] ONE_Q14   = 17'd16384;
    localparam logic [16:0] TWO_Q14   = 17'd32768;
    localparam logic [16:0] THREE_Q14 = 17'd49152;

    // Rounding offsets
    localparam logic signed [63:0] RND_30 = 64'sd536870912;
    localparam logic signed [63:0] RND_28 = 64'sd134217728;

    // Multiplier operand A select
    localparam logic [2:0] OPA_ACT1  = 3'd0;
    localparam logic [2:0] OPA_ACT2  = 3'd1;
    localparam logic [2:0] OPA_U     = 3'd2;
    localparam logic [2:0] OPA_H     = 3'd3;
    localparam logic [2:0] OPA_A     = 3'd4;
    localparam logic [2:0] OPA_FORCE = 3'd5;
    localparam logic [2:0] OPA_N     = 3'd6;

    // Multiplier operand B select
    localparam logic [2:0] OPB_A1    = 3'd0;
    localparam logic [2:0] OPB_A2    = 3'd1;
    localparam logic [2:0] OPB_V     = 3'd2;
    localparam logic [2:0] OPB_PROD  = 3'd3;
    localparam logic [2:0] OPB_K136  = 3'd4;
    localparam logic [2:0] OPB_K211  = 3'd5;
    localparam logic [2:0] OPB_RECIP = 3'd6;

    // Accumulator operation
    localparam logic [1:0] ACC_NOP  = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;

    // Write-back operation
    localparam logic [2:0] WB_NONE = 3'd0;
    localparam logic [2:0] WB_H    = 3'd1;
    localparam logic [2:0] WB_A    = 3'd2;
    localparam logic [2:0] WB_AZ   = 3'd3;
    localparam logic [2:0] WB_N    = 3'd4;
    localparam logic [2:0] WB_T    = 3'd5;

    // Jump condition
    localparam logic [1:0] JMP_NONE   = 2'd0;
    localparam logic [1:0] JMP_ALWAYS = 2'd1;
    localparam logic [1:0] JMP_WZERO  = 2'd2;

    // Program addresses that are jump targets or bounds
    localparam logic [PC_W-1:0] STEP_AZERO = 4'd6;
    localparam logic [PC_W-1:0] STEP_SCALE = 4'd7;
    localparam logic [PC_W-1:0] STEP_LAST  = 4'd12;

    typedef struct packed {
        logic            mul_en;
        logic [2:0]      opa;
        logic [2:0]      opb;
        logic [1:0]      acc_op;
        logic [2:0]      wb;
        logic [1:0]      jmp;
        logic [PC_W-1:0] target;
        logic            last;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic   load;   // input transfer this cycle
        logic   run;    // current control word executes
        ucode_t word;
    } seq_ctrl_t;

    function automatic ucode_t uc(
        input logic            mul_en,
        input logic [2:0]      opa,
        input logic [2:0]      opb,
        input logic [1:0]      acc_op,
        input logic [2:0]      wb,
        input logic [1:0]      jmp,
        input logic [PC_W-1:0] target,
        input logic            last
    );
        ucode_t w;
        w.mul_en = mul_en;
        w.opa    = opa;
        w.opb    = opb;
        w.acc_op = acc_op;
        w.wb     = wb;
        w.jmp    = jmp;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // Control program; a product is usable in the step after its multiply
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        case (addr)
            // filter feedback: acc = A1*act1 - A2*act2
            4'd0:  w = uc(1'b1, OPA_ACT1, OPB_A1, ACC_NOP, WB_NONE, JMP_NONE, '0, 1'b0);
            4'd1:  w = uc(1'b1, OPA_ACT2, OPB_A2, ACC_LOAD, WB_NONE, JMP_NONE, '0, 1'b0);
            // length weight u*v
            4'd2:  w = uc(1'b1, OPA_U, OPB_V, ACC_SUB, WB_NONE, JMP_NONE, '0, 1'b0);
            // h; weight outside its support skips the scaling
            4'd3:  w = uc(1'b0, OPA_H, OPB_PROD, ACC_NOP, WB_H, JMP_WZERO, STEP_AZERO, 1'b0);
            4'd4:  w = uc(1'b1, OPA_H, OPB_PROD, ACC_NOP, WB_NONE, JMP_NONE, '0, 1'b0);
            4'd5:  w = uc(1'b0, OPA_H, OPB_PROD, ACC_NOP, WB_A, JMP_ALWAYS, STEP_SCALE, 1'b0);
            4'd6:  w = uc(1'b0, OPA_H, OPB_PROD, ACC_NOP, WB_AZ, JMP_NONE, '0, 1'b0);
            // force numerator: acc = 136*A - 211*T
            4'd7:  w = uc(1'b1, OPA_A, OPB_K136, ACC_NOP, WB_NONE, JMP_NONE, '0, 1'b0);
            4'd8:  w = uc(1'b1, OPA_FORCE, OPB_K211, ACC_LOAD, WB_NONE, JMP_NONE, '0, 1'b0);
            4'd9:  w = uc(1'b0, OPA_FORCE, OPB_K211, ACC_SUB, WB_NONE, JMP_NONE, '0, 1'b0);
            // divide by 51200: shift by 11, then multiply by reciprocal of 25
            4'd10: w = uc(1'b0, OPA_N, OPB_RECIP, ACC_NOP, WB_N, JMP_NONE, '0, 1'b0);
            4'd11: w = uc(1'b1, OPA_N, OPB_RECIP, ACC_NOP, WB_NONE, JMP_NONE, '0, 1'b0);
            4'd12: w = uc(1'b0, OPA_N, OPB_RECIP, ACC_NOP, WB_T, JMP_NONE, '0, 1'b1);
            default: w = uc(1'b0, OPA_ACT1, OPB_A1, ACC_NOP, WB_NONE, JMP_NONE, '0, 1'b0);
        endcase
        return w;
    endfunction

    // Clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/mfs_useq.sv]
// Microcode sequencer: step counter, control ROM, jumps and stream handshakes.
// Depends on mfs_pkg.
module mfs_useq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic               wzero,
    output mfs_pkg::seq_ctrl_t ctrl
);

    logic                     busy_reg, busy_next;
    logic [mfs_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                     out_valid_reg, out_valid_next;
    mfs_pkg::ucode_t          word;
    logic                     accept;
    logic                     stall;
    logic                     run;
    logic                     jump_taken;

    assign word     = mfs_pkg::ucode_rom(pc_reg);
    assign in_ready = !busy_reg;
    assign accept   = in_valid && !busy_reg;

    // Final step commits into the result register; hold it while that is full and not being taken
    assign stall = word.last && out_valid_reg && !out_ready;
    assign run   = busy_reg && !stall;

    assign jump_taken = (word.jmp == mfs_pkg::JMP_ALWAYS)
                     || ((word.jmp == mfs_pkg::JMP_WZERO) && wzero);

    // Step counter, busy flag and result valid flag
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (run)
        begin
            if (word.last)
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else if (jump_taken)
                pc_next = word.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ctrl.load = accept;
    assign ctrl.run  = run;
    assign ctrl.word = word;

`ifndef SYNTHESIS
    // program counter never leaves the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= mfs_pkg::STEP_LAST))
        else $error("pc outside program");

    // a transfer starts the program at its first step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && (pc_reg == '0)))
        else $error("program did not start");

    // a result appears only from a finished program
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && word.last))
        else $error("result without final step");

    // program end always leaves a pending result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> out_valid_reg)
        else $error("program ended without result");
`endif

endmodule

[rtl/mfs_datapath.sv]
// Datapath: shared multiplier, accumulator, model state and result register.
// Driven by the control word from mfs_useq; depends on mfs_pkg.
module mfs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mfs_pkg::seq_ctrl_t                  ctrl,
    input  logic [mfs_pkg::LEN_W-1:0]           length_sample,
    input  logic                                start_req,
    input  logic [mfs_pkg::PERIOD_W-1:0]        spike_period,
    output logic                                wzero,
    output logic signed [mfs_pkg::DATA_W-1:0]   force_res,
    output logic signed [mfs_pkg::DATA_W-1:0]   activation,
    output logic                                spike
);

    // Model state
    logic [mfs_pkg::PERIOD_W-1:0] phase_reg;
    logic                         sp1_reg;
    logic signed [31:0]           act1_reg;
    logic signed [31:0]           act2_reg;
    logic signed [31:0]           force_reg;

    // Working registers
    logic [15:0]        x_reg;
    logic               fire_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] h_reg;
    logic signed [31:0] a_reg;
    logic [28:0]        n_reg;
    logic               neg_reg;
    logic signed [31:0] out_force_reg;
    logic signed [31:0] out_act_reg;
    logic               out_spike_reg;

    logic               wb_run;
    logic               fire_now;
    logic [16:0]        x2;
    logic [15:0]        u_val, v_val;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_next;
    logic signed [63:0] acc_rnd;
    logic signed [33:0] h_fb;
    logic signed [35:0] h_sum;
    logic signed [31:0] h_val;
    logic signed [63:0] prod_rnd;
    logic signed [63:0] mag;
    logic [39:0]        m_val;
    logic signed [33:0] q_s;
    logic signed [33:0] t_sum;
    logic signed [31:0] t_val;
    logic [mfs_pkg::PERIOD_W-1:0] period_eff;
    logic [mfs_pkg::PERIOD_W:0]   ph_inc;
    logic [mfs_pkg::PERIOD_W-1:0] ph_next;
    logic               commit;

    assign wb_run = ctrl.run;
    assign commit = wb_run && (ctrl.word.wb == mfs_pkg::WB_T);

    // Spike rule; a start transfer sees a cleared phase
    assign fire_now = (spike_period <= 11'd1)
                   || (!start_req && (phase_reg == 11'd1));

    // Phase advance; zero period acts as one
    assign period_eff = (spike_period == '0) ? 11'd1 : spike_period;
    assign ph_inc     = {1'b0, phase_reg} + 1'b1;
    assign ph_next    = (ph_inc >= {1'b0, period_eff}) ? '0 : ph_inc[10:0];

    // Length weight as u*v: (2x-1)(3-2x) below one, x(2-x) from one to two
    assign x2 = {x_reg, 1'b0};
    always_comb
    begin
        u_val = '0;
        v_val = '0;
        if (x_reg[15:14] == 2'b00)
        begin
            u_val = 16'(x2 - mfs_pkg::ONE_Q14);
            v_val = 16'(mfs_pkg::THREE_Q14 - x2);
        end
        else
        begin
            u_val = x_reg;
            v_val = 16'(mfs_pkg::TWO_Q14 - {1'b0, x_reg});
        end
    end
    assign wzero = x_reg[15] || (x_reg[15:13] == 3'b000);

    // Operand selection
    always_comb
    begin
        case (ctrl.word.opa)
            mfs_pkg::OPA_ACT1:  mul_a = act1_reg;
            mfs_pkg::OPA_ACT2:  mul_a = act2_reg;
            mfs_pkg::OPA_U:     mul_a = {16'b0, u_val};
            mfs_pkg::OPA_H:     mul_a = h_reg;
            mfs_pkg::OPA_A:     mul_a = a_reg;
            mfs_pkg::OPA_FORCE: mul_a = force_reg;
            mfs_pkg::OPA_N:     mul_a = {3'b0, n_reg};
            default:            mul_a = '0;
        endcase
        case (ctrl.word.opb)
            mfs_pkg::OPB_A1:    mul_b = mfs_pkg::COEF_A1;
            mfs_pkg::OPB_A2:    mul_b = mfs_pkg::COEF_A2;
            mfs_pkg::OPB_V:     mul_b = {16'b0, v_val};
            mfs_pkg::OPB_PROD:  mul_b = prod_reg[31:0];
            mfs_pkg::OPB_K136:  mul_b = mfs_pkg::KSE_NUM;
            mfs_pkg::OPB_K211:  mul_b = mfs_pkg::DAMP_NUM;
            mfs_pkg::OPB_RECIP: mul_b = mfs_pkg::RECIP_25;
            default:            mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // h: feedback rounded half up to Q16.16, plus spike terms, saturated
    assign acc_rnd = acc_reg + mfs_pkg::RND_30;
    assign h_fb    = acc_rnd[63:30];
    assign h_sum   = 36'(h_fb)
                   + (fire_reg ? 36'(mfs_pkg::COEF_B0_Q16) : 36'sd0)
                   - (sp1_reg  ? 36'(mfs_pkg::COEF_B1_Q16) : 36'sd0);
    assign h_val   = mfs_pkg::sat32(40'(h_sum));

    // A = h*w rounded half up from Q.44
    assign prod_rnd = prod_reg + mfs_pkg::RND_28;

    // |num| + 25600, then /2048 exactly; remaining /25 is by reciprocal
    assign mag   = acc_reg[63] ? -acc_reg : acc_reg;
    assign m_val = mag[39:0] + mfs_pkg::STEP_HALF;

    // Signed increment and saturating force update
    assign q_s   = {9'b0, prod_reg[58:34]};
    assign t_sum = 34'(force_reg) + (neg_reg ? -q_s : q_s);
    assign t_val = mfs_pkg::sat32(40'(t_sum));

    // Model state: cleared by reset or a start transfer, updated at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            sp1_reg   <= 1'b0;
            act1_reg  <= '0;
            act2_reg  <= '0;
            force_reg <= '0;
        end
        else if (ctrl.load && start_req)
        begin
            phase_reg <= '0;
            sp1_reg   <= 1'b0;
            act1_reg  <= '0;
            act2_reg  <= '0;
            force_reg <= '0;
        end
        else if (commit)
        begin
            phase_reg <= ph_next;
            sp1_reg   <= fire_reg;
            act1_reg  <= h_reg;
            act2_reg  <= act1_reg;
            force_reg <= t_val;
        end
    end

    // Working registers and result register
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg    <= length_sample;
            fire_reg <= fire_now;
        end
        if (wb_run && ctrl.word.mul_en)
            prod_reg <= prod_next;
        if (wb_run)
        begin
            case (ctrl.word.acc_op)
                mfs_pkg::ACC_LOAD: acc_reg <= prod_reg;
                mfs_pkg::ACC_SUB:  acc_reg <= acc_reg - prod_reg;
                default:           acc_reg <= acc_reg;
            endcase
            case (ctrl.word.wb)
                mfs_pkg::WB_H:  h_reg <= h_val;
                mfs_pkg::WB_A:  a_reg <= prod_rnd[59:28];
                mfs_pkg::WB_AZ: a_reg <= '0;
                mfs_pkg::WB_N:
                begin
                    n_reg   <= m_val[39:11];
                    neg_reg <= acc_reg[63];
                end
                mfs_pkg::WB_T:
                begin
                    out_force_reg <= t_val;
                    out_act_reg   <= h_reg;
                    out_spike_reg <= fire_reg;
                end
                default: ;
            endcase
        end
    end

    assign force_res  = out_force_reg;
    assign activation = out_act_reg;
    assign spike      = out_spike_reg;

endmodule

[rtl/muscle_force_step.sv]
// Top level of the muscle force step: spike period register, sequencer, datapath.
// Depends on mfs_pkg, mfs_useq and mfs_datapath.
//
//  channel   | direction | tdata                         | tuser
//  ----------+-----------+-------------------------------+-----------
//  s_axis    | in        | [15:0] length_sample          | start_req
//  m_axis    | out       | [31:0] force_res,             | spike
//            |           | [63:32] activation            |
//  spike_period_we/wdata | register write, no read-back  |
//
// An item is taken in its transfer cycle and then walks step by step through the
// control program on one shared 32x32 multiplier. A length outside the weight's
// support skips the scaling steps, so the walk is shorter.
// The result's tvalid rises when the final step commits, and s_axis_tready rises
// again with it.
// The final step waits while an earlier result is still untaken.
// Reset sets the spike period to 102 and clears the model state; a start_req
// transfer clears the state as well.
module muscle_force_step (
    input  logic        clk,
    input  logic        rst_n,
    // length_sample [15:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // start_req
    input  logic        s_axis_tuser,
    // force_res [31:0], activation [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    // spike
    output logic        m_axis_tuser,
    input  logic        spike_period_we,
    input  logic [10:0] spike_period_wdata
);

    logic [mfs_pkg::PERIOD_W-1:0] spike_period_reg;
    mfs_pkg::seq_ctrl_t           ctrl;
    logic                         wzero;
    logic signed [31:0]           force_res;
    logic signed [31:0]           activation;
    logic                         spike;

    // Spike period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spike_period_reg <= mfs_pkg::PERIOD_RESET;
        else if (spike_period_we)
            spike_period_reg <= spike_period_wdata;
    end

    mfs_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .wzero     (wzero),
        .ctrl      (ctrl)
    );

    mfs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .length_sample (s_axis_tdata),
        .start_req     (s_axis_tuser),
        .spike_period  (spike_period_reg),
        .wzero         (wzero),
        .force_res     (force_res),
        .activation    (activation),
        .spike         (spike)
    );

    assign m_axis_tdata = {activation, force_res};
    assign m_axis_tuser = spike;

endmodule
